[src/rnvp_pkg.sv]
`default_nettype none

package rnvp_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W = 12;
  localparam int INDEX_CAP = (MAX_VERTICES > 4096) ? 4095 : MAX_VERTICES - 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int DIST_W = 52;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [26:0] P_CLAMP = 27'h4000000;

  localparam logic [23:0] ORIGIN_RESET = 24'd0;
  localparam logic [15:0] DIR_XY_RESET = 16'd0;
  localparam logic [15:0] DIR_Z_RESET = 16'd16384;
  localparam logic [22:0] THRESH_RESET = 23'd2048;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_DIR_X     = 3'd3,
    REG_DIR_Y     = 3'd4,
    REG_DIR_Z     = 3'd5,
    REG_THRESHOLD = 3'd6
  } rnvp_reg_t;

  typedef struct packed {
    logic [23:0] origin_x;
    logic [23:0] origin_y;
    logic [23:0] origin_z;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [22:0] thresh;
  } rnvp_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ovf;
    logic             last;
  } rnvp_tag_t;

  typedef struct packed {
    logic [24:0] dx;
    logic [24:0] dy;
    logic [24:0] dz;
    rnvp_tag_t   tag;
  } rnvp_item_t;

endpackage

`default_nettype wire

[src/rnvp_front.sv]
`default_nettype none

module rnvp_front
  import rnvp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rnvp_cfg_t  cfg,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic       in_tlast,
  output logic            push_valid,
  input  wire logic       push_ready,
  output rnvp_item_t      push_item
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;
  logic             ovf_hit;
  logic [IDX_W-1:0] idx;
  logic [23:0]      vx, vy, vz;

  assign vx = in_tdata[23:0];
  assign vy = in_tdata[47:24];
  assign vz = in_tdata[71:48];

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;
  assign accept     = in_tvalid & push_ready;

  // index saturates at the cap, overflow sticks until the end of the list
  assign ovf_hit = (cnt_r >= CNT_W'(MAX_VERTICES));
  assign idx = (cnt_r > CNT_W'(INDEX_CAP)) ? IDX_W'(INDEX_CAP) : IDX_W'(cnt_r);

  always_comb begin
    push_item.dx       = {vx[23], vx} - {cfg.origin_x[23], cfg.origin_x};
    push_item.dy       = {vy[23], vy} - {cfg.origin_y[23], cfg.origin_y};
    push_item.dz       = {vz[23], vz} - {cfg.origin_z[23], cfg.origin_z};
    push_item.tag.idx  = idx;
    push_item.tag.ovf  = ovf_r | ovf_hit;
    push_item.tag.last = in_tlast;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      if (in_tlast) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        if (!ovf_hit) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        ovf_nxt = ovf_r | ovf_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

[src/rnvp_queue.sv]
`default_nettype none

module rnvp_queue
  import rnvp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_valid,
  output logic            push_ready,
  input  wire rnvp_item_t push_item,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output rnvp_item_t      pop_item
);

  rnvp_item_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[src/rnvp_back.sv]
`default_nettype none

module rnvp_back
  import rnvp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rnvp_cfg_t   cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rnvp_item_t  in_item,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata
);

  logic adv;

  logic signed [24:0] d_in  [3];
  logic signed [15:0] dir_s [3];

  // stage 1: d * dir
  logic               v1_r;
  rnvp_tag_t          tag1_r;
  logic signed [24:0] d1_r [3];
  logic signed [40:0] m1_r [3];
  logic signed [40:0] m1_nxt [3];

  // stage 2: projection t rounded to q.0, the units of d
  logic               v2_r;
  rnvp_tag_t          tag2_r;
  logic signed [24:0] d2_r [3];
  logic signed [27:0] t12_r;
  logic               skip2_r;
  logic signed [42:0] t_sum;
  logic signed [42:0] t_rnd;
  logic signed [27:0] t12_nxt;

  // stage 3: dir * t
  logic               v3_r;
  rnvp_tag_t          tag3_r;
  logic signed [24:0] d3_r [3];
  logic signed [43:0] m3_r [3];
  logic               skip3_r;
  logic signed [43:0] m3_nxt [3];

  // stage 4: clamped offset magnitude
  logic               v4_r;
  rnvp_tag_t          tag4_r;
  logic [26:0]        a4_r [3];
  logic               skip4_r;
  logic signed [43:0] m3_rnd [3];
  logic signed [29:0] q3 [3];
  logic signed [31:0] p3 [3];
  logic [31:0]        mag3 [3];
  logic [26:0]        a4_nxt [3];

  // stage 5: squares
  logic               v5_r;
  rnvp_tag_t          tag5_r;
  logic [53:0]        sq5_r [3];
  logic               skip5_r;
  logic [53:0]        sq5_nxt [3];

  // stage 6: saturated distance
  logic               v6_r;
  rnvp_tag_t          tag6_r;
  logic [DIST_W-1:0]  dist6_r;
  logic               skip6_r;
  logic [55:0]        sq_sum;
  logic [DIST_W-1:0]  dist6_nxt;

  // running minimum
  logic               best_valid_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [45:0]        thr_sq_r;
  logic [DIST_W-1:0]  limit;
  logic               take;
  logic               nb_valid;
  logic [IDX_W-1:0]   nb_idx;
  logic [DIST_W-1:0]  nb_dist;

  // result register
  logic               out_valid_r;
  logic               out_found_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_ovf_r;

  assign adv      = !out_valid_r || out_tready;
  assign in_ready = adv;

  assign d_in[0]  = $signed(in_item.dx);
  assign d_in[1]  = $signed(in_item.dy);
  assign d_in[2]  = $signed(in_item.dz);
  assign dir_s[0] = $signed(cfg.dir_x);
  assign dir_s[1] = $signed(cfg.dir_y);
  assign dir_s[2] = $signed(cfg.dir_z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1_nxt[i] = d_in[i] * dir_s[i];
    end
  end

  // t < 0 is judged on the exact sum, then add half and floor
  always_comb begin
    t_sum   = 43'(m1_r[0]) + 43'(m1_r[1]) + 43'(m1_r[2]);
    t_rnd   = t_sum + 43'sd8192;
    t12_nxt = t_rnd[41:14];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m3_nxt[i] = dir_s[i] * t12_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m3_rnd[i] = m3_r[i] + 44'sd8192;
      q3[i]     = m3_rnd[i][43:14];
      p3[i]     = 32'(d3_r[i]) - 32'(q3[i]);
      mag3[i]   = p3[i][31] ? -p3[i] : p3[i];
      a4_nxt[i] = (mag3[i] > 32'(P_CLAMP)) ? P_CLAMP : mag3[i][26:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq5_nxt[i] = 54'(a4_r[i]) * 54'(a4_r[i]);
    end
  end

  always_comb begin
    sq_sum    = 56'(sq5_r[0]) + 56'(sq5_r[1]) + 56'(sq5_r[2]);
    dist6_nxt = (sq_sum > 56'(DIST_MAX)) ? DIST_MAX : sq_sum[DIST_W-1:0];
  end

  // before any hit the limit is the squared threshold, afterwards the held minimum
  always_comb begin
    limit    = best_valid_r ? best_dist_r : DIST_W'(thr_sq_r);
    take     = v6_r && !skip6_r && (dist6_r < limit);
    nb_valid = best_valid_r | take;
    nb_idx   = take ? tag6_r.idx : best_idx_r;
    nb_dist  = take ? dist6_r : best_dist_r;
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= 46'(cfg.thresh) * 46'(cfg.thresh);
    if (adv) begin
      tag1_r  <= in_item.tag;
      d1_r    <= d_in;
      m1_r    <= m1_nxt;
      tag2_r  <= tag1_r;
      d2_r    <= d1_r;
      t12_r   <= t12_nxt;
      skip2_r <= t_sum[42];
      tag3_r  <= tag2_r;
      d3_r    <= d2_r;
      m3_r    <= m3_nxt;
      skip3_r <= skip2_r;
      tag4_r  <= tag3_r;
      a4_r    <= a4_nxt;
      skip4_r <= skip3_r;
      tag5_r  <= tag4_r;
      sq5_r   <= sq5_nxt;
      skip5_r <= skip4_r;
      tag6_r  <= tag5_r;
      dist6_r <= dist6_nxt;
      skip6_r <= skip5_r;
      if (v6_r && tag6_r.last) begin
        out_found_r <= nb_valid;
        out_idx_r   <= nb_valid ? nb_idx : '0;
        out_dist_r  <= nb_valid ? nb_dist : '0;
        out_ovf_r   <= tag6_r.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      v6_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      best_valid_r <= 1'b0;
      best_idx_r   <= '0;
      best_dist_r  <= '0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r & tag6_r.last;
      if (v6_r && tag6_r.last) begin
        best_valid_r <= 1'b0;
        best_idx_r   <= '0;
        best_dist_r  <= '0;
      end else begin
        best_valid_r <= nb_valid;
        best_idx_r   <= nb_idx;
        best_dist_r  <= nb_dist;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_ovf_r, out_dist_r, out_idx_r, out_found_r};

`ifndef NO_ASSERTIONS
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_idx_r == '0 && out_dist_r == '0)
    else $error("result without a hit carries nonzero fields");

  a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v6_r && tag6_r.last |=> out_valid_r)
    else $error("last vertex left the pipe without a result");

  a_last_clears_best: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v6_r && tag6_r.last |=> !best_valid_r && best_dist_r == '0)
    else $error("running minimum not cleared after last vertex");

  // bubbles may carry unknown data, so the distance is only checked behind a real item
  a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v6_r) && $stable(best_dist_r) && (!v6_r || $stable(dist6_r)))
    else $error("pipeline moved while the result was stalled");
`endif

endmodule

`default_nettype wire

[src/ray_nearest_vertex_pick_unit.sv]
// channel  | dir | ports                                  | item
// in       | in  | in_tvalid/in_tready/in_tdata/in_tlast  | vertex x,y,z; tlast ends the list
// out      | out | out_tvalid/out_tready/out_tdata        | one pick result per list
// cfg      | in  | cfg_psel/penable/pwrite/paddr/pwdata   | ray origin, direction, threshold
//
// one vertex per cycle unless stalled; the queue and the six-stage arithmetic pipe run
// at that rate and only the running-minimum compare in the last stage feeds back
// a result goes via the queue, the pipe stages and the result register to out_tvalid
// rst_n is synchronous; it clears list state and restores the register defaults
// a stalled result holds the back pipe, the four-entry queue keeps taking vertices until full
`default_nettype none

module ray_nearest_vertex_pick_unit
  import rnvp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,     // vertex_x[23:0], vertex_y[47:24], vertex_z[71:48]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,    // found[0], closest_index[12:1],
                                         // closest_dist_sq[64:13], count_overflow[65]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  rnvp_cfg_t  cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_sel;
  logic       push_valid, push_ready;
  rnvp_item_t push_item;
  logic       pop_valid, pop_ready;
  rnvp_item_t pop_item;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_ORIGIN_X:  cfg_nxt.origin_x = cfg_pwdata[23:0];
        REG_ORIGIN_Y:  cfg_nxt.origin_y = cfg_pwdata[23:0];
        REG_ORIGIN_Z:  cfg_nxt.origin_z = cfg_pwdata[23:0];
        REG_DIR_X:     cfg_nxt.dir_x    = cfg_pwdata[15:0];
        REG_DIR_Y:     cfg_nxt.dir_y    = cfg_pwdata[15:0];
        REG_DIR_Z:     cfg_nxt.dir_z    = cfg_pwdata[15:0];
        REG_THRESHOLD: cfg_nxt.thresh   = cfg_pwdata[22:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ORIGIN_X:  cfg_prdata = 32'(cfg_r.origin_x);
      REG_ORIGIN_Y:  cfg_prdata = 32'(cfg_r.origin_y);
      REG_ORIGIN_Z:  cfg_prdata = 32'(cfg_r.origin_z);
      REG_DIR_X:     cfg_prdata = 32'(cfg_r.dir_x);
      REG_DIR_Y:     cfg_prdata = 32'(cfg_r.dir_y);
      REG_DIR_Z:     cfg_prdata = 32'(cfg_r.dir_z);
      REG_THRESHOLD: cfg_prdata = 32'(cfg_r.thresh);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= ORIGIN_RESET;
      cfg_r.origin_y <= ORIGIN_RESET;
      cfg_r.origin_z <= ORIGIN_RESET;
      cfg_r.dir_x    <= DIR_XY_RESET;
      cfg_r.dir_y    <= DIR_XY_RESET;
      cfg_r.dir_z    <= DIR_Z_RESET;
      cfg_r.thresh   <= THRESH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rnvp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  rnvp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  rnvp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (pop_valid),
    .in_ready   (pop_ready),
    .in_item    (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
